### hdl/prime_table_trial_division_macros.svh
// Assertion helpers shared by the prime table RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PRIME_TABLE_TRIAL_DIVISION_MACROS_SVH
`define PRIME_TABLE_TRIAL_DIVISION_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PTD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ptd_pkg.sv
`default_nettype none

package ptd_pkg;

	// Defaults for the top-level parameters
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 16;

	// Fixed port widths
	localparam int CAND_W   = 16;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 11;

	// Preload contents
	localparam int PRELOAD_COUNT   = 168;
	localparam int PRELOAD_LARGEST = 997;
	localparam int SMALLEST_PRIME  = 2;
	localparam int PRIME_W         = 10;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_NORMAL    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_ABOVE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	// Status of the serial remainder unit toward the sequencer
	typedef struct packed {
		logic done;
		logic rem_zero;
		logic q_lt_div;
	} ptd_div_res_t;

	// Primes below 1000, ascending
	localparam logic [PRIME_W-1:0] PRELOAD_PRIMES [0:PRELOAD_COUNT-1] = '{
		10'd2, 10'd3, 10'd5, 10'd7, 10'd11, 10'd13, 10'd17, 10'd19, 10'd23, 10'd29,
		10'd31, 10'd37, 10'd41, 10'd43, 10'd47, 10'd53, 10'd59, 10'd61, 10'd67, 10'd71,
		10'd73, 10'd79, 10'd83, 10'd89, 10'd97, 10'd101, 10'd103, 10'd107, 10'd109,
		10'd113, 10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157,
		10'd163, 10'd167, 10'd173, 10'd179, 10'd181, 10'd191, 10'd193, 10'd197,
		10'd199, 10'd211, 10'd223, 10'd227, 10'd229, 10'd233, 10'd239, 10'd241,
		10'd251, 10'd257, 10'd263, 10'd269, 10'd271, 10'd277, 10'd281, 10'd283,
		10'd293, 10'd307, 10'd311, 10'd313, 10'd317, 10'd331, 10'd337, 10'd347,
		10'd349, 10'd353, 10'd359, 10'd367, 10'd373, 10'd379, 10'd383, 10'd389,
		10'd397, 10'd401, 10'd409, 10'd419, 10'd421, 10'd431, 10'd433, 10'd439,
		10'd443, 10'd449, 10'd457, 10'd461, 10'd463, 10'd467, 10'd479, 10'd487,
		10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541, 10'd547,
		10'd557, 10'd563, 10'd569, 10'd571, 10'd577, 10'd587, 10'd593, 10'd599,
		10'd601, 10'd607, 10'd613, 10'd617, 10'd619, 10'd631, 10'd641, 10'd643,
		10'd647, 10'd653, 10'd659, 10'd661, 10'd673, 10'd677, 10'd683, 10'd691,
		10'd701, 10'd709, 10'd719, 10'd727, 10'd733, 10'd739, 10'd743, 10'd751,
		10'd757, 10'd761, 10'd769, 10'd773, 10'd787, 10'd797, 10'd809, 10'd811,
		10'd821, 10'd823, 10'd827, 10'd829, 10'd839, 10'd853, 10'd857, 10'd859,
		10'd863, 10'd877, 10'd881, 10'd883, 10'd887, 10'd907, 10'd911, 10'd919,
		10'd929, 10'd937, 10'd941, 10'd947, 10'd953, 10'd967, 10'd971, 10'd977,
		10'd983, 10'd991, 10'd997
	};

endpackage

`default_nettype wire

### hdl/ptd_ram.sv
`default_nettype none

module ptd_ram #(
	parameter int WIDTH = ptd_pkg::VALUE_WIDTH_DEF,
	parameter int DEPTH = ptd_pkg::TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one port, read one port with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/ptd_rem_serial.sv
`default_nettype none

module ptd_rem_serial #(
	parameter int VALUE_WIDTH = ptd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [VALUE_WIDTH-1:0]   dividend,
	input  logic [VALUE_WIDTH-1:0]   divisor,
	output ptd_pkg::ptd_div_res_t    res
);

	import ptd_pkg::*;

	localparam int CNTW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] div_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [VALUE_WIDTH:0]   shifted;
	logic [VALUE_WIDTH:0]   diff;
	logic                   fits;

	// Bring down the next dividend bit and try one subtraction
	assign shifted = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = shifted >= {1'b0, div_q};

	// Count the steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift quotient bits in behind the dividend, keep the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], fits};
		end
	end

	// Report the finished division
	assign res.done     = done_q;
	assign res.rem_zero = (rem_q == '0);
	assign res.q_lt_div = (dvd_q < div_q);

endmodule

`default_nettype wire

### hdl/prime_table_trial_division.sv
// Prime table with trial division, one bit-serial remainder step per cycle.
// Each stored divisor takes a table read, a load, VALUE_WIDTH steps and a check.
// Candidates zero and one skip the trial divisions and go straight to the result.
// One candidate at a time; the result register lets the next start while the last waits.
// Reset is asynchronous; afterwards a preload writes the 168 primes below 1000.
`default_nettype none

module prime_table_trial_division #(
	parameter int TABLE_DEPTH = ptd_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = ptd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ptd_pkg::CAND_W-1:0]    candidate,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_prime,
	output logic [ptd_pkg::STATUS_W-1:0]  status,
	output logic [ptd_pkg::TOTAL_W-1:0]   prime_total
);

	import ptd_pkg::*;

	`include "prime_table_trial_division_macros.svh"

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;
	localparam int FW = $clog2(PRELOAD_COUNT);
	localparam int TW = (CW > TOTAL_W) ? CW : TOTAL_W;

	localparam logic [2:0] ST_FILL  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]             state_q;
	logic [FW-1:0]          fill_q;
	logic [VALUE_WIDTH-1:0] cand_q;
	logic [VALUE_WIDTH-1:0] largest_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          idx_q;
	logic                   prime_q;
	logic                   out_valid_q;
	logic                   is_prime_q;
	logic [STATUS_W-1:0]    status_q;
	logic [TOTAL_W-1:0]     total_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic [VALUE_WIDTH-1:0] ram_rdata;
	logic                   div_start;
	ptd_div_res_t           div_res;

	logic [VALUE_WIDTH-1:0] cand_in;
	logic                   out_free;
	logic                   cand_above;
	logic                   table_full;
	logic                   append;
	logic [STATUS_W-1:0]    status_n;
	logic [CW-1:0]          count_n;
	logic [TW-1:0]          count_ext;
	logic [CW-1:0]          idx_next;

	// Handshake and decisions for the current transaction
	assign in_ready   = (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || out_ready;
	assign cand_in    = VALUE_WIDTH'(candidate);
	assign cand_above = cand_q > largest_q;
	assign table_full = (count_q == CW'(TABLE_DEPTH));
	assign append     = (state_q == ST_FIN) && out_free && cand_above && prime_q && !table_full;
	assign count_n    = append ? count_q + CW'(1) : count_q;
	assign count_ext  = TW'(count_n);
	assign idx_next   = idx_q + CW'(1);

	// Classify the candidate against the largest stored prime and the table fill
	always_comb begin
		if (!cand_above) begin
			status_n = STATUS_NOT_ABOVE;
		end else if (prime_q && table_full) begin
			status_n = STATUS_FULL;
		end else begin
			status_n = STATUS_NORMAL;
		end
	end

	// Write the preload during fill, appended primes afterwards
	always_comb begin
		if (state_q == ST_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(fill_q);
			ram_wdata = VALUE_WIDTH'(PRELOAD_PRIMES[fill_q]);
		end else begin
			ram_we    = append;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = cand_q;
		end
	end

	ptd_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign div_start = (state_q == ST_START);

	ptd_rem_serial #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cand_q),
		.divisor  (ram_rdata),
		.res      (div_res)
	);

	// Sequence the fill, the trial divisions and the table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			fill_q      <= '0;
			count_q     <= CW'(PRELOAD_COUNT);
			largest_q   <= VALUE_WIDTH'(PRELOAD_LARGEST);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_FILL: begin
					fill_q <= fill_q + FW'(1);
					if (fill_q == FW'(PRELOAD_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (cand_in < VALUE_WIDTH'(SMALLEST_PRIME)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						if (div_res.q_lt_div || div_res.rem_zero || idx_next == count_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q     <= count_n;
						if (append) begin
							largest_q <= cand_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the candidate, the divisor index and the verdict
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cand_q  <= cand_in;
			idx_q   <= '0;
			prime_q <= 1'b0;
		end else if (state_q == ST_DIV && div_res.done) begin
			idx_q <= idx_next;
			if (div_res.q_lt_div) begin
				prime_q <= 1'b1;
			end else if (div_res.rem_zero) begin
				prime_q <= 1'b0;
			end else if (idx_next == count_q) begin
				prime_q <= 1'b1;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			is_prime_q <= prime_q;
			status_q   <= status_n;
			total_q    <= count_ext[TOTAL_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign is_prime    = is_prime_q;
	assign status      = status_q;
	assign prime_total = total_q;

	`PTD_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= CW'(TABLE_DEPTH), "prime count beyond depth")
	`PTD_ASSERT_NOW(a_done_in_div, div_res.done, state_q == ST_DIV, "remainder done outside divide")
	`PTD_ASSERT_NEXT(a_append_largest, append, largest_q == $past(cand_q), "largest not updated")
	`PTD_ASSERT_NEXT(a_append_count, append, count_q == $past(count_q) + CW'(1), "count not advanced")

endmodule

`default_nettype wire
